FILE: sv/yyw_pkg.sv
`timescale 1ns / 1ps
package yyw_pkg;
   localparam int FRAC = 20;
   localparam int WW = 32;
   localparam int TW = FRAC + 2;
   localparam int IW = 3;
   localparam int SQ_STEPS = FRAC + 1;
   localparam int DIV_STEPS = WW + FRAC;
   localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [WW-1:0] ONE = WW'(64'sd1 <<< FRAC);
   localparam logic signed [WW-1:0] HALF = WW'(64'sd1 <<< (FRAC - 1));

   localparam logic [IW-1:0] REG_RADIUS = 3'd0;
   localparam logic [IW-1:0] REG_COS_A = 3'd1;
   localparam logic [IW-1:0] REG_SIN_A = 3'd2;
   localparam logic [IW-1:0] REG_COS_B = 3'd3;
   localparam logic [IW-1:0] REG_SIN_B = 3'd4;
   localparam logic [IW-1:0] REG_DUAL = 3'd5;
   localparam logic [IW-1:0] REG_PASS = 3'd6;
   localparam logic [IW-1:0] REG_WEIGHT = 3'd7;

   function automatic logic signed [WW-1:0] sat(input logic signed [2*WW+1:0] v);
      if (v > $signed({{(WW+2){1'b0}}, WMAX})) return WMAX;
      if (v < $signed({{(WW+2){1'b1}}, WMIN})) return WMIN;
      return v[WW-1:0];
   endfunction

   function automatic logic signed [WW-1:0] fmul(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
      logic signed [2*WW-1:0] p;
      logic [2*WW-1:0] m;
      logic signed [2*WW+1:0] r;
      p = a * b;
      m = p[2*WW-1] ? -p : p;
      m = m >> FRAC;
      r = p[2*WW-1] ? -$signed({2'b00, m}) : $signed({2'b00, m});
      return sat(r);
   endfunction

   function automatic logic signed [WW-1:0] sadd(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
      return sat((2*WW+2)'(a) + (2*WW+2)'(b));
   endfunction

   function automatic logic signed [WW-1:0] ssub(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
      return sat((2*WW+2)'(a) - (2*WW+2)'(b));
   endfunction

   function automatic logic signed [WW-1:0] nsat(input logic signed [WW-1:0] a);
      return (a == WMIN) ? WMAX : -a;
   endfunction

   typedef struct packed {
      logic signed [WW-1:0] radius;
      logic signed [TW-1:0] cos_a;
      logic signed [TW-1:0] sin_a;
      logic signed [TW-1:0] cos_b;
      logic signed [TW-1:0] sin_b;
      logic dual;
      logic pass;
      logic signed [WW-1:0] weight;
   } cfg_type;
endpackage

FILE: sv/yin_yang_point_warp.sv
`timescale 1ns / 1ps
// Path from input accept to output valid: 3 front stages, sqrt (22), divide (53),
// 3 middle stages, sqrt (22), 3 output stages.
// Throughput: one item per cycle while not held; sqrt and divider take one bit per stage.
// The whole pipe advances together and holds when the output stage is full and not taken.
// Reset clears valid bits and loads the register defaults (radius 0.5, identity rotations,
// dual mode on, outside points zeroed, weight 1.0).
module yin_yang_point_warp (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic req_pick_second,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_delta_x,
   output logic signed [31:0] rsp_delta_y,
   output logic signed [31:0] rsp_delta_z,
   input  logic csr_write,
   input  logic [yyw_pkg::IW-1:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int W = yyw_pkg::WW;
   localparam int LSQ = yyw_pkg::SQ_STEPS + 1;
   localparam int LDV = yyw_pkg::DIV_STEPS + 1;
   localparam int D1 = LSQ;
   localparam int D2 = LDV;
   localparam int D3 = LSQ;
   typedef logic signed [W-1:0] w_type;

   typedef struct packed {
      logic ins;
      logic inv;
      logic upper;
      w_type x;
      w_type y;
      w_type z;
      w_type nx;
      w_type ny;
      w_type rr;
      w_type t;
      w_type k;
      w_type t1;
      w_type k1;
      w_type off;
      w_type p;
   } item_type;

   yyw_pkg::cfg_type cfg_ff;
   logic adv;
   logic [D1+D2+D3+8:0] v_ff;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius <= yyw_pkg::HALF;
         cfg_ff.cos_a <= yyw_pkg::TW'(yyw_pkg::ONE);
         cfg_ff.sin_a <= '0;
         cfg_ff.cos_b <= yyw_pkg::TW'(yyw_pkg::ONE);
         cfg_ff.sin_b <= '0;
         cfg_ff.dual <= 1'b1;
         cfg_ff.pass <= 1'b0;
         cfg_ff.weight <= yyw_pkg::ONE;
      end else if (csr_write) begin
         case (csr_index)
            yyw_pkg::REG_RADIUS: cfg_ff.radius <= csr_data;
            yyw_pkg::REG_COS_A: cfg_ff.cos_a <= csr_data[yyw_pkg::TW-1:0];
            yyw_pkg::REG_SIN_A: cfg_ff.sin_a <= csr_data[yyw_pkg::TW-1:0];
            yyw_pkg::REG_COS_B: cfg_ff.cos_b <= csr_data[yyw_pkg::TW-1:0];
            yyw_pkg::REG_SIN_B: cfg_ff.sin_b <= csr_data[yyw_pkg::TW-1:0];
            yyw_pkg::REG_DUAL: cfg_ff.dual <= csr_data[0];
            yyw_pkg::REG_PASS: cfg_ff.pass <= csr_data[0];
            yyw_pkg::REG_WEIGHT: cfg_ff.weight <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[D1+D2+D3+7:0], req_valid};
   end

   // stage a: squares, rotation products
   item_type a_ff, b_ff, c_ff;
   w_type xx_ff, yy_ff, xc_ff, ys_ff, xs_ff, yc_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic sel;
         w_type c, s;
         item_type it;
         sel = cfg_ff.dual && req_pick_second;
         c = sel ? W'(cfg_ff.cos_b) : W'(cfg_ff.cos_a);
         s = sel ? W'(cfg_ff.sin_b) : W'(cfg_ff.sin_a);
         it = '0;
         it.x = req_pos_x;
         it.y = req_pos_y;
         it.z = req_pos_z;
         it.inv = sel;
         it.rr = sel ? yyw_pkg::ssub(yyw_pkg::ONE, cfg_ff.radius) : cfg_ff.radius;
         a_ff <= it;
         xx_ff <= yyw_pkg::fmul(req_pos_x, req_pos_x);
         yy_ff <= yyw_pkg::fmul(req_pos_y, req_pos_y);
         xc_ff <= yyw_pkg::fmul(req_pos_x, c);
         ys_ff <= yyw_pkg::fmul(req_pos_y, s);
         xs_ff <= yyw_pkg::fmul(req_pos_x, s);
         yc_ff <= yyw_pkg::fmul(req_pos_y, c);
      end
   end

   w_type ny2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         w_type ny;
         item_type it;
         ny = yyw_pkg::sadd(xs_ff, yc_ff);
         it = a_ff;
         it.ins = yyw_pkg::sadd(xx_ff, yy_ff) < yyw_pkg::ONE;
         it.nx = yyw_pkg::ssub(xc_ff, ys_ff);
         it.ny = ny;
         it.upper = ny > 0;
         b_ff <= it;
         ny2_ff <= yyw_pkg::fmul(ny, ny);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_type it;
         it = b_ff;
         it.t = yyw_pkg::ssub(yyw_pkg::ONE, ny2_ff);
         c_ff <= it;
      end
   end

   // first root: t
   item_type d1_ff [D1];
   w_type t_root;
   yyw_sqrt u_sq1 (.clock(clock), .en(adv), .arg(c_ff.t), .root(t_root));
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff[0] <= c_ff;
         for (int i = 1; i < D1; i++) d1_ff[i] <= d1_ff[i-1];
      end
   end
   item_type e_it;
   always_comb begin
      e_it = d1_ff[D1-1];
      e_it.t = t_root;
   end

   // divide nx / t
   item_type d2_ff [D2];
   w_type k_q;
   yyw_div u_div (.clock(clock), .en(adv), .num(e_it.nx), .den(e_it.t), .quo(k_q));
   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff[0] <= e_it;
         for (int i = 1; i < D2; i++) d2_ff[i] <= d2_ff[i-1];
      end
   end

   item_type f_ff, g_ff, h_ff;
   w_type ar_ff, am_ff, t1sq_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         w_type d, alfa, sm;
         item_type it;
         it = d2_ff[D2-1];
         it.k = k_q;
         d = yyw_pkg::ssub(it.t, yyw_pkg::HALF);
         it.t1 = yyw_pkg::sadd(d, d);
         sm = yyw_pkg::ssub(yyw_pkg::ONE, k_q);
         alfa = (sm < 0) ? -((-sm) >>> 1) : (sm >>> 1);
         it.p = yyw_pkg::ssub(yyw_pkg::ONE, alfa);
         it.k1 = alfa;
         f_ff <= it;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff <= f_ff;
         ar_ff <= yyw_pkg::fmul(f_ff.k1, f_ff.rr);
         am_ff <= yyw_pkg::fmul(f_ff.k1, yyw_pkg::ssub(f_ff.rr, yyw_pkg::ONE));
         t1sq_ff <= yyw_pkg::fmul(f_ff.t1, f_ff.t1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_type it;
         it = g_ff;
         it.k1 = yyw_pkg::sadd(ar_ff, g_ff.p);
         it.off = am_ff;
         it.t = yyw_pkg::ssub(yyw_pkg::ONE, t1sq_ff);
         h_ff <= it;
      end
   end

   // second root
   item_type d3_ff [D3];
   w_type r2_root;
   yyw_sqrt u_sq2 (.clock(clock), .en(adv), .arg(h_ff.t), .root(r2_root));
   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff[0] <= h_ff;
         for (int i = 1; i < D3; i++) d3_ff[i] <= d3_ff[i-1];
      end
   end

   // final: form pre-weight terms (upper-lens y is weighted here), weight multiply, then zero or negate
   item_type m_ff;
   w_type ax_ff, ay_ff;
   logic zero_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         item_type it;
         w_type sc;
         it = d3_ff[D3-1];
         m_ff <= it;
         sc = yyw_pkg::ssub(yyw_pkg::ONE, it.rr);
         zero_ff <= !it.ins && !cfg_ff.pass;
         if (!it.ins) begin
            ax_ff <= it.x;
            ay_ff <= it.y;
         end else if (it.upper) begin
            ax_ff <= yyw_pkg::sadd(yyw_pkg::fmul(it.t1, it.k1), it.off);
            ay_ff <= yyw_pkg::fmul(cfg_ff.weight, r2_root);
         end else begin
            ax_ff <= yyw_pkg::sadd(yyw_pkg::fmul(it.nx, sc), it.rr);
            ay_ff <= yyw_pkg::fmul(it.ny, sc);
         end
      end
   end

   w_type bx_ff, by_ff, bz_ff;
   item_type n_ff;
   logic zero2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff <= m_ff;
         zero2_ff <= zero_ff;
         bx_ff <= yyw_pkg::fmul(cfg_ff.weight, ax_ff);
         by_ff <= (m_ff.ins && m_ff.upper) ? yyw_pkg::fmul(ay_ff, m_ff.k1)
                                           : yyw_pkg::fmul(cfg_ff.weight, ay_ff);
         bz_ff <= yyw_pkg::fmul(cfg_ff.weight, m_ff.z);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (zero2_ff) begin
            rsp_delta_x <= '0;
            rsp_delta_y <= '0;
         end else if (n_ff.ins && n_ff.inv) begin
            rsp_delta_x <= yyw_pkg::nsat(bx_ff);
            rsp_delta_y <= yyw_pkg::nsat(by_ff);
         end else begin
            rsp_delta_x <= bx_ff;
            rsp_delta_y <= by_ff;
         end
         rsp_delta_z <= bz_ff;
      end
   end

   assign rsp_valid = v_ff[D1+D2+D3+8];
endmodule

FILE: sv/yyw_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of a Q value clamped to [0, 1.0]; one bit pair per stage.
module yyw_sqrt (
   input  logic clock,
   input  logic en,
   input  logic signed [yyw_pkg::WW-1:0] arg,
   output logic signed [yyw_pkg::WW-1:0] root
);
   localparam int NW = 2 * yyw_pkg::FRAC + 2;
   localparam int S = yyw_pkg::SQ_STEPS;
   logic [NW-1:0] n_ff [S+1];
   logic [NW-1:0] r_ff [S+1];
   logic [NW-1:0] n_in;

   always_comb begin
      if (arg <= 0) n_in = '0;
      else if (arg > yyw_pkg::ONE) n_in = NW'(yyw_pkg::ONE) << yyw_pkg::FRAC;
      else n_in = NW'(arg) << yyw_pkg::FRAC;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= n_in;
         r_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < S; i++) begin : g_st
      localparam logic [NW-1:0] BIT = NW'(1) << (2 * (S - 1 - i));
      always_ff @(posedge clock) begin
         if (en) begin
            if (n_ff[i] >= r_ff[i] + BIT) begin
               n_ff[i+1] <= n_ff[i] - (r_ff[i] + BIT);
               r_ff[i+1] <= (r_ff[i] >> 1) + BIT;
            end else begin
               n_ff[i+1] <= n_ff[i];
               r_ff[i+1] <= r_ff[i] >> 1;
            end
         end
      end
   end

   assign root = yyw_pkg::WW'(r_ff[S]);
endmodule

FILE: sv/yyw_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: (a << FRAC) / b, one quotient bit per stage, with sat.
module yyw_div (
   input  logic clock,
   input  logic en,
   input  logic signed [yyw_pkg::WW-1:0] num,
   input  logic signed [yyw_pkg::WW-1:0] den,
   output logic signed [yyw_pkg::WW-1:0] quo
);
   localparam int S = yyw_pkg::DIV_STEPS;
   localparam int RW = yyw_pkg::WW + 1;
   logic [S-1:0] n_ff [S+1];
   logic [S-1:0] q_ff [S+1];
   logic [RW-1:0] r_ff [S+1];
   logic [yyw_pkg::WW-1:0] d_ff [S+1];
   logic neg_ff [S+1];
   logic zero_ff [S+1];
   logic pos_ff [S+1];
   logic [yyw_pkg::WW-1:0] ua;
   logic [yyw_pkg::WW-1:0] ub;

   assign ua = num[yyw_pkg::WW-1] ? -num : num;
   assign ub = den[yyw_pkg::WW-1] ? -den : den;

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= S'(ua) << yyw_pkg::FRAC;
         q_ff[0] <= '0;
         r_ff[0] <= '0;
         d_ff[0] <= ub;
         neg_ff[0] <= num[yyw_pkg::WW-1] ^ den[yyw_pkg::WW-1];
         zero_ff[0] <= (den == 0);
         pos_ff[0] <= (num > 0);
      end
   end

   for (genvar i = 0; i < S; i++) begin : g_st
      logic [RW-1:0] rs;
      assign rs = {r_ff[i][RW-2:0], n_ff[i][S-1-i]};
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[i+1] <= n_ff[i];
            d_ff[i+1] <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            pos_ff[i+1] <= pos_ff[i];
            if (rs >= {1'b0, d_ff[i]}) begin
               r_ff[i+1] <= rs - {1'b0, d_ff[i]};
               q_ff[i+1] <= q_ff[i] | (S'(1) << (S - 1 - i));
            end else begin
               r_ff[i+1] <= rs;
               q_ff[i+1] <= q_ff[i];
            end
         end
      end
   end

   logic [S-1:0] q;
   assign q = q_ff[S];
   always_comb begin
      if (zero_ff[S]) quo = pos_ff[S] ? yyw_pkg::WMAX : (n_ff[S] != 0 ? yyw_pkg::WMIN : '0);
      else if (neg_ff[S]) quo = (q >= S'(yyw_pkg::WMAX) + S'(1)) ? yyw_pkg::WMIN
                                 : -$signed(yyw_pkg::WW'(q));
      else quo = (q >= S'(yyw_pkg::WMAX)) ? yyw_pkg::WMAX : $signed(yyw_pkg::WW'(q));
   end
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam longint QONE = 64'sd1 << yyw_pkg::FRAC;
   localparam longint QHALF = 64'sd1 << (yyw_pkg::FRAC - 1);
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      int x;
      int y;
      int z;
      bit pick;
   } point_type;

   typedef struct {
      int dx;
      int dy;
      int dz;
   } delta_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [31:0] req_pos_z;
   logic req_pick_second;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_delta_x;
   logic signed [31:0] rsp_delta_y;
   logic signed [31:0] rsp_delta_z;
   logic csr_write;
   logic [yyw_pkg::IW-1:0] csr_index;
   logic [31:0] csr_data;

   yin_yang_point_warp uut (.*);

   // warp settings as the block should hold them
   longint eye_radius, cos_a, sin_a, cos_b, sin_b, gain;
   bit dual_on, pass_on;

   point_type pending_points[$];
   delta_type expected_deltas[$];
   int send_idle_pct, recv_idle_pct;
   logic req_fire;
   bit failed = 1'b0;
   int cycles = 0;

   function automatic longint clamp(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = m >>> yyw_pkg::FRAC;
      return clamp((p < 0) ? -m : m);
   endfunction

   function automatic longint qadd(longint a, longint b);
      return clamp(a + b);
   endfunction

   function automatic longint qsub(longint a, longint b);
      return clamp(a - b);
   endfunction

   function automatic longint qneg(longint a);
      return (a == QMIN) ? QMAX : -a;
   endfunction

   function automatic longint qdiv(longint a, longint b);
      longint ua, ub, q;
      if (b == 0) return (a > 0) ? QMAX : ((a < 0) ? QMIN : 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      q = (ua << yyw_pkg::FRAC) / ub;
      return clamp(((a < 0) != (b < 0)) ? -q : q);
   endfunction

   function automatic longint qsqrt(longint v);
      longint n, r, c;
      if (v <= 0) return 0;
      n = ((v > QONE) ? QONE : v) << yyw_pkg::FRAC;
      r = 0;
      for (int i = yyw_pkg::FRAC; i >= 0; i--) begin
         c = r | (64'sd1 << i);
         if (c * c <= n) r = c;
      end
      return clamp(r);
   endfunction

   function automatic delta_type warp_point(point_type p);
      delta_type d;
      longint x, y, r2, c, s, rr, nx, ny, t, k, t1, alfa, beta, off, k1, dx, dy, sc;
      bit mirror;
      x = p.x;
      y = p.y;
      dx = 0;
      dy = 0;
      r2 = qadd(qmul(x, x), qmul(y, y));
      if (r2 < QONE) begin
         mirror = dual_on && p.pick;
         c = mirror ? cos_b : cos_a;
         s = mirror ? sin_b : sin_a;
         rr = mirror ? qsub(QONE, eye_radius) : eye_radius;
         nx = qsub(qmul(x, c), qmul(y, s));
         ny = qadd(qmul(x, s), qmul(y, c));
         if (ny > 0) begin
            // lens on the circle arc
            t = qsqrt(qsub(QONE, qmul(ny, ny)));
            k = qdiv(nx, t);
            t1 = qsub(t, QHALF);
            t1 = qadd(t1, t1);
            alfa = qsub(QONE, k) / 2;
            beta = qsub(QONE, alfa);
            off = qmul(alfa, qsub(rr, QONE));
            k1 = qadd(qmul(alfa, rr), beta);
            dx = qmul(gain, qadd(qmul(t1, k1), off));
            dy = qmul(qmul(gain, qsqrt(qsub(QONE, qmul(t1, t1)))), k1);
         end else begin
            sc = qsub(QONE, rr);
            dx = qmul(gain, qadd(qmul(nx, sc), rr));
            dy = qmul(gain, qmul(ny, sc));
         end
         if (mirror) begin
            dx = qneg(dx);
            dy = qneg(dy);
         end
      end else if (pass_on) begin
         dx = qmul(gain, x);
         dy = qmul(gain, y);
      end
      d.dx = int'(dx);
      d.dy = int'(dy);
      d.dz = int'(qmul(gain, longint'(p.z)));
      return d;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // driver: hold an item until it is taken
   always @(negedge clock) begin
      point_type p;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_valid && !req_fire) begin
            // hold
         end else if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            p = pending_points.pop_front();
            req_valid <= 1'b1;
            req_pos_x <= p.x;
            req_pos_y <= p.y;
            req_pos_z <= p.z;
            req_pick_second <= p.pick;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      point_type p;
      delta_type e;
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.x = req_pos_x;
            p.y = req_pos_y;
            p.z = req_pos_z;
            p.pick = req_pick_second;
            expected_deltas.push_back(warp_point(p));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_deltas.size() == 0) begin
               $error("unexpected item dx=%0d dy=%0d dz=%0d",
                      rsp_delta_x, rsp_delta_y, rsp_delta_z);
               failed = 1'b1;
            end else begin
               e = expected_deltas.pop_front();
               if (rsp_delta_x !== e.dx) begin
                  $error("delta_x expected %0d got %0d", e.dx, rsp_delta_x);
                  failed = 1'b1;
               end
               if (rsp_delta_y !== e.dy) begin
                  $error("delta_y expected %0d got %0d", e.dy, rsp_delta_y);
                  failed = 1'b1;
               end
               if (rsp_delta_z !== e.dz) begin
                  $error("delta_z expected %0d got %0d", e.dz, rsp_delta_z);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   task automatic write_reg(logic [yyw_pkg::IW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         yyw_pkg::REG_RADIUS: eye_radius = longint'($signed(val));
         yyw_pkg::REG_COS_A: cos_a = longint'($signed(val[yyw_pkg::TW-1:0]));
         yyw_pkg::REG_SIN_A: sin_a = longint'($signed(val[yyw_pkg::TW-1:0]));
         yyw_pkg::REG_COS_B: cos_b = longint'($signed(val[yyw_pkg::TW-1:0]));
         yyw_pkg::REG_SIN_B: sin_b = longint'($signed(val[yyw_pkg::TW-1:0]));
         yyw_pkg::REG_DUAL: dual_on = val[0];
         yyw_pkg::REG_PASS: pass_on = val[0];
         yyw_pkg::REG_WEIGHT: gain = longint'($signed(val));
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(int rad, int ca, int sa, int cb, int sb, bit dual, bit pass,
                            int wt);
      write_reg(yyw_pkg::REG_RADIUS, rad);
      write_reg(yyw_pkg::REG_COS_A, ca);
      write_reg(yyw_pkg::REG_SIN_A, sa);
      write_reg(yyw_pkg::REG_COS_B, cb);
      write_reg(yyw_pkg::REG_SIN_B, sb);
      write_reg(yyw_pkg::REG_DUAL, {31'd0, dual});
      write_reg(yyw_pkg::REG_PASS, {31'd0, pass});
      write_reg(yyw_pkg::REG_WEIGHT, wt);
   endtask

   task automatic add_point(int x, int y, int z, bit pick);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.pick = pick;
      pending_points.push_back(p);
   endtask

   function automatic int rand_coord();
      int r;
      r = $urandom_range(9);
      if (r < 6) return int'($urandom_range(32'(2 * QONE))) - int'(QONE);
      if (r < 8) return ($urandom_range(1) ? 1 : -1) * (int'(QONE) - int'($urandom_range(4096)));
      return $urandom;
   endfunction

   function automatic int rand_trig();
      case ($urandom_range(3))
         0: return -int'(QONE);
         1: return int'(QONE);
         default: return int'($urandom_range(32'(2 * QONE))) - int'(QONE);
      endcase
   endfunction

   task automatic add_random(int count);
      repeat (count) add_point(rand_coord(), rand_coord(), $urandom, 1'($urandom_range(1)));
   endtask

   task automatic drain();
      while (pending_points.size() > 0 || req_valid || expected_deltas.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int one_q;
      one_q = int'(QONE);
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_pick_second = 1'b0;
      rsp_ready = 1'b0;
      req_fire = 1'b0;
      csr_write = 1'b0;
      csr_index = yyw_pkg::REG_RADIUS;
      csr_data = '0;
      send_idle_pct = 9;
      recv_idle_pct = 73;
      eye_radius = QHALF;
      cos_a = QONE;
      sin_a = 0;
      cos_b = QONE;
      sin_b = 0;
      dual_on = 1'b1;
      pass_on = 1'b0;
      gain = QONE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed points at the reset settings
      add_point(0, 0, 0, 0);
      add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      add_point(32'h80000000, 32'h80000000, 32'h80000000, 1);
      add_point(one_q, 0, one_q, 0);
      add_point(0, -one_q, -one_q, 1);
      add_point(one_q - 1, 0, 5, 0);
      add_point(0, one_q - 1, 7, 0);
      add_point(0, one_q - 1, 7, 1);
      add_point(314573, 524288, 1000, 0);
      add_point(314573, 524288, 1000, 1);
      add_point(314573, -524288, -1000, 0);
      add_point(314573, -524288, -1000, 1);
      add_point(-943718, 104858, 3, 0);
      add_point(-943718, -104858, 3, 1);
      add_point(741455, 741455, 0, 0);
      add_point(0, 1, 32'h80000000, 1);
      drain();

      // lens with t at zero, dual off, pass on, weight at the smallest word
      write_all(0, one_q, one_q, one_q, one_q, 0, 1, 32'h80000000);
      add_point(0, one_q - 1, 1, 1);
      add_point(524288, 524288, 2, 0);
      add_point(-524288, 524288, 3, 1);
      add_point(one_q, one_q, 4, 0);
      add_point(32'h80000000, 32'h7fffffff, 5, 1);
      add_point(-1, -524288, 6, 0);
      drain();

      write_all($urandom_range(one_q), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                1, 1, one_q);
      add_random(75);
      // pause the sender until every result is back
      drain();
      add_random(75);
      drain();
      write_all(32'h7fffffff, one_q, one_q, -one_q, -one_q, 1, 0, 32'h7fffffff);
      add_random(150);
      drain();

      send_idle_pct = 73;
      recv_idle_pct = 9;
      write_all(32'h80000000, rand_trig(), rand_trig(), rand_trig(), rand_trig(), 0, 1,
                32'h80000000);
      add_random(150);
      drain();
      write_all($urandom, one_q, 0, 0, one_q, 1, 0, $urandom);
      add_random(150);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_all(0, -one_q, 0, 0, -one_q, 0, 0, $urandom);
      add_random(150);
      drain();
      write_all($urandom_range(one_q), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                1, 1, one_q);
      add_random(150);
      drain();

      if (expected_deltas.size() > 0) begin
         $error("%0d items never came out", expected_deltas.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
